// ===== src/wsfr_pkg.sv =====
// Shared types and constants for the WebSocket frame receiver.
package wsfr_pkg;

  localparam logic [7:0] HdrFinBit   = 8'h80;
  localparam logic [7:0] OpcodeMask  = 8'h0F;
  localparam logic [7:0] Len7Mask    = 8'h7F;
  localparam logic [6:0] Len16Code   = 7'd126;
  localparam logic [6:0] Len64Code   = 7'd127;
  localparam logic [3:0] Len16Bytes  = 4'd2;
  localparam logic [3:0] Len64Bytes  = 4'd8;
  localparam logic [3:0] KeyBytes    = 4'd4;

  localparam logic KindHeader  = 1'b0;
  localparam logic KindPayload = 1'b1;

  typedef enum logic [4:0] {
    PH_FIRST   = 5'b00001,
    PH_SECOND  = 5'b00010,
    PH_EXTLEN  = 5'b00100,
    PH_KEY     = 5'b01000,
    PH_PAYLOAD = 5'b10000
  } wsfr_phase_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } wsfr_item_t;

  typedef struct packed {
    logic        kind;
    logic        fin;
    logic [3:0]  opcode;
    logic        masked;
    logic [63:0] frame_length;
    logic [7:0]  data_byte;
    logic        last;
  } wsfr_result_t;

endpackage

// ===== src/wsfr_in_reg.sv =====
// Input register stage holding one received byte.
module wsfr_in_reg
  import wsfr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [7:0] in_byte,
  output logic       in_stall,
  input  logic       advance,
  output wsfr_item_t item
);

  logic       valid_r, valid_nxt;
  logic [7:0] data_r, data_nxt;

  assign in_stall = valid_r && !advance;

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (!in_stall) begin
      valid_nxt = in_valid;
      data_nxt  = in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    data_r <= data_nxt;
  end

  assign item.valid = valid_r;
  assign item.data  = data_r;

endmodule

// ===== src/wsfr_parser.sv =====
// Frame header parser, payload unmasking and frame state.
module wsfr_parser
  import wsfr_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         fire,
  input  logic [7:0]   data,
  output logic         res_valid,
  output wsfr_result_t res
);

  wsfr_phase_t phase_r, phase_nxt;
  logic        fin_r, fin_nxt;
  logic [3:0]  op_r, op_nxt;
  logic        mask_r, mask_nxt;
  logic [63:0] len_r, len_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [31:0] key_r, key_nxt;
  logic [63:0] rem_r, rem_nxt;
  logic [1:0]  idx_r, idx_nxt;

  logic        len_done;
  logic        hdr_done;
  logic [6:0]  len7;
  logic [31:0] key_sh;
  logic [7:0]  pay_byte;
  logic        pay_last;

  always_comb begin
    phase_nxt = phase_r;
    fin_nxt   = fin_r;
    op_nxt    = op_r;
    mask_nxt  = mask_r;
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    key_nxt   = key_r;
    rem_nxt   = rem_r;
    idx_nxt   = idx_r;
    len_done  = 1'b0;
    hdr_done  = 1'b0;
    res_valid = 1'b0;
    len7      = data[6:0] & Len7Mask[6:0];
    key_sh    = key_r << {idx_r, 3'b000};
    pay_byte  = data ^ (mask_r ? key_sh[31:24] : 8'h00);
    pay_last  = (rem_r[63:1] == 63'd0);
    res       = '0;

    unique case (phase_r)
      PH_SECOND: begin
        mask_nxt = data[7];
        if (len7 == Len16Code || len7 == Len64Code) begin
          cnt_nxt   = (len7 == Len16Code) ? Len16Bytes : Len64Bytes;
          len_nxt   = '0;
          phase_nxt = PH_EXTLEN;
        end else begin
          len_nxt  = {57'd0, len7};
          len_done = 1'b1;
        end
      end
      PH_EXTLEN: begin
        len_nxt = {len_r[55:0], data};
        cnt_nxt = cnt_r - 4'd1;
        if (cnt_nxt == 4'd0) begin
          len_done = 1'b1;
        end
      end
      PH_KEY: begin
        key_nxt = {key_r[23:0], data};
        cnt_nxt = cnt_r - 4'd1;
        if (cnt_nxt == 4'd0) begin
          hdr_done = 1'b1;
        end
      end
      PH_PAYLOAD: begin
        idx_nxt = idx_r + 2'd1;
        if (rem_r != 64'd0) begin
          rem_nxt = rem_r - 64'd1;
        end
        if (pay_last) begin
          phase_nxt = PH_FIRST;
        end
        res_valid        = 1'b1;
        res.kind         = KindPayload;
        res.data_byte    = pay_byte;
        res.last         = pay_last;
      end
      default: begin
        fin_nxt   = |(data & HdrFinBit);
        op_nxt    = data[3:0] & OpcodeMask[3:0];
        phase_nxt = PH_SECOND;
      end
    endcase

    if (len_done) begin
      if (mask_nxt) begin
        key_nxt   = '0;
        cnt_nxt   = KeyBytes;
        phase_nxt = PH_KEY;
      end else begin
        hdr_done = 1'b1;
      end
    end

    if (hdr_done) begin
      rem_nxt       = len_nxt;
      idx_nxt       = '0;
      cnt_nxt       = '0;
      phase_nxt     = (len_nxt == 64'd0) ? PH_FIRST : PH_PAYLOAD;
      res_valid     = 1'b1;
      res.kind      = KindHeader;
      res.data_byte = '0;
      res.last      = (len_nxt == 64'd0);
    end

    res.fin          = fin_nxt;
    res.opcode       = op_nxt;
    res.masked       = mask_nxt;
    res.frame_length = len_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FIRST;
      fin_r   <= 1'b0;
      op_r    <= '0;
      mask_r  <= 1'b0;
      len_r   <= '0;
      cnt_r   <= '0;
      key_r   <= '0;
      rem_r   <= '0;
      idx_r   <= '0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      fin_r   <= fin_nxt;
      op_r    <= op_nxt;
      mask_r  <= mask_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
      key_r   <= key_nxt;
      rem_r   <= rem_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

// ===== src/wsfr_out_reg.sv =====
// Result register driving the output channel.
module wsfr_out_reg
  import wsfr_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         load,
  input  wsfr_result_t res,
  input  logic         out_stall,
  output logic         out_valid,
  output wsfr_result_t out_res
);

  logic         valid_r, valid_nxt;
  wsfr_result_t res_r, res_nxt;

  always_comb begin
    valid_nxt = valid_r;
    res_nxt   = res_r;
    if (load) begin
      valid_nxt = 1'b1;
      res_nxt   = res;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    res_r <= res_nxt;
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

// ===== src/websocket_frame_receiver_core.sv =====
// A result is loaded into the result register when its byte leaves the input register.
// Throughput: one byte per cycle; the input register and the result register
// stand either side of the parser, so a byte moves on whenever the result
// register is empty or being drained.
// Reset (rst_n, synchronous): both stages empty, parser waits for a first header byte.
module websocket_frame_receiver_core
  import wsfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic [7:0]  in_byte,
  output logic        in_stall,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_kind,
  output logic        out_fin,
  output logic [3:0]  out_opcode,
  output logic        out_masked,
  output logic [63:0] out_frame_length,
  output logic [7:0]  out_data_byte,
  output logic        out_last
);

  wsfr_item_t   item;
  wsfr_result_t res;
  wsfr_result_t out_res;
  logic         res_valid;
  logic         advance;

  assign advance = item.valid && (!out_valid || !out_stall);

  wsfr_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_byte  (in_byte),
    .in_stall (in_stall),
    .advance  (advance),
    .item     (item)
  );

  wsfr_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (advance),
    .data      (item.data),
    .res_valid (res_valid),
    .res       (res)
  );

  wsfr_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance && res_valid),
    .res       (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  assign out_kind         = out_res.kind;
  assign out_fin          = out_res.fin;
  assign out_opcode       = out_res.opcode;
  assign out_masked       = out_res.masked;
  assign out_frame_length = out_res.frame_length;
  assign out_data_byte    = out_res.data_byte;
  assign out_last         = out_res.last;

endmodule

// ===== tb/wsfr_frame_checker.sv =====
// Frame decode predictor and result checker for the WebSocket frame receiver.
`timescale 1ns / 1ps

module wsfr_frame_checker
  import wsfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic [7:0]  in_byte,
  input  logic        in_stall,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_kind,
  input  logic        out_fin,
  input  logic [3:0]  out_opcode,
  input  logic        out_masked,
  input  logic [63:0] out_frame_length,
  input  logic [7:0]  out_data_byte,
  input  logic        out_last,
  output int          n_errors,
  output int          n_pending,
  output int          n_headers,
  output int          n_payload
);

  wsfr_result_t expected_q[$];

  wsfr_phase_t st_phase   = PH_FIRST;
  logic        hdr_fin    = 1'b0;
  logic [3:0]  hdr_opcode = '0;
  logic        hdr_masked = 1'b0;
  logic [63:0] frame_len  = '0;
  logic [3:0]  hdr_left   = '0;
  logic [31:0] key_word   = '0;
  logic [63:0] bytes_left = '0;
  logic [1:0]  key_pos    = '0;

  int err_cnt = 0;
  int hdr_cnt = 0;
  int pay_cnt = 0;

  task report_mismatch(input string what, input logic [63:0] got, input logic [63:0] want);
    err_cnt++;
    if (err_cnt <= 30)
      $display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
  endtask

  task push_result(input logic kind, input logic [7:0] data, input logic last);
    wsfr_result_t r;
    r.kind         = kind;
    r.fin          = hdr_fin;
    r.opcode       = hdr_opcode;
    r.masked       = hdr_masked;
    r.frame_length = frame_len;
    r.data_byte    = data;
    r.last         = last;
    expected_q.push_back(r);
  endtask

  task header_done();
    bytes_left = frame_len;
    key_pos    = '0;
    hdr_left   = '0;
    st_phase   = (frame_len == 64'd0) ? PH_FIRST : PH_PAYLOAD;
    push_result(KindHeader, 8'h00, frame_len == 64'd0);
  endtask

  // key bytes follow only when the mask bit is set
  task length_done();
    if (hdr_masked) begin
      key_word = '0;
      hdr_left = KeyBytes;
      st_phase = PH_KEY;
    end else begin
      header_done();
    end
  endtask

  task decode_byte(input logic [7:0] b);
    logic [6:0] len7;
    logic [7:0] d;
    logic       last;
    case (st_phase)
      PH_SECOND: begin
        hdr_masked = |(b & HdrFinBit);
        len7 = 7'(b & Len7Mask);
        if (len7 == Len16Code || len7 == Len64Code) begin
          hdr_left  = (len7 == Len16Code) ? Len16Bytes : Len64Bytes;
          frame_len = '0;
          st_phase  = PH_EXTLEN;
        end else begin
          frame_len = {57'd0, len7};
          length_done();
        end
      end
      PH_EXTLEN: begin
        frame_len = {frame_len[55:0], b};
        hdr_left  = hdr_left - 4'd1;
        if (hdr_left == 4'd0) length_done();
      end
      PH_KEY: begin
        key_word = {key_word[23:0], b};
        hdr_left = hdr_left - 4'd1;
        if (hdr_left == 4'd0) header_done();
      end
      PH_PAYLOAD: begin
        d = b;
        if (hdr_masked) d = b ^ key_word[8*(3-int'(key_pos)) +: 8];
        key_pos = key_pos + 2'd1;
        last = (bytes_left <= 64'd1);
        if (bytes_left != 64'd0) bytes_left = bytes_left - 64'd1;
        if (last) st_phase = PH_FIRST;
        push_result(KindPayload, d, last);
      end
      default: begin
        hdr_fin    = |(b & HdrFinBit);
        hdr_opcode = 4'(b & OpcodeMask);
        st_phase   = PH_SECOND;
      end
    endcase
  endtask

  task check_result();
    wsfr_result_t want;
    if (expected_q.size() == 0) begin
      report_mismatch("result transfer with nothing expected, kind", 64'(out_kind), 64'd0);
    end else begin
      want = expected_q.pop_front();
      if (out_kind !== want.kind)
        report_mismatch("kind", 64'(out_kind), 64'(want.kind));
      if (out_fin !== want.fin)
        report_mismatch("fin", 64'(out_fin), 64'(want.fin));
      if (out_opcode !== want.opcode)
        report_mismatch("opcode", 64'(out_opcode), 64'(want.opcode));
      if (out_masked !== want.masked)
        report_mismatch("masked", 64'(out_masked), 64'(want.masked));
      if (out_frame_length !== want.frame_length)
        report_mismatch("frame_length", out_frame_length, want.frame_length);
      if (out_data_byte !== want.data_byte)
        report_mismatch("data_byte", 64'(out_data_byte), 64'(want.data_byte));
      if (out_last !== want.last)
        report_mismatch("last", 64'(out_last), 64'(want.last));
      if (want.kind == KindHeader) hdr_cnt++;
      else pay_cnt++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid === 1'b1 && out_stall === 1'b0) check_result();
      if (in_valid === 1'b1 && in_stall === 1'b0) decode_byte(in_byte);
    end
    n_errors  <= err_cnt;
    n_pending <= expected_q.size();
    n_headers <= hdr_cnt;
    n_payload <= pay_cnt;
  end

endmodule

// ===== tb/tb.sv =====
// Top-level testbench: clock, reset, frame stimulus, result-side stalls and verdict.
`timescale 1ns / 1ps

module tb
  import wsfr_pkg::*;
;

  typedef enum int {FORM_7, FORM_16, FORM_64} len_form_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic [7:0]  in_byte;
  logic        in_stall;
  logic        out_valid;
  logic        out_stall;
  logic        out_kind;
  logic        out_fin;
  logic [3:0]  out_opcode;
  logic        out_masked;
  logic [63:0] out_frame_length;
  logic [7:0]  out_data_byte;
  logic        out_last;

  int n_errors;
  int n_pending;
  int n_headers;
  int n_payload;

  int sent_bytes = 0;
  int sent_frames = 0;
  bit quiet = 0;

  websocket_frame_receiver_core u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_byte          (in_byte),
    .in_stall         (in_stall),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_fin          (out_fin),
    .out_opcode       (out_opcode),
    .out_masked       (out_masked),
    .out_frame_length (out_frame_length),
    .out_data_byte    (out_data_byte),
    .out_last         (out_last)
  );

  wsfr_frame_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_byte          (in_byte),
    .in_stall         (in_stall),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_fin          (out_fin),
    .out_opcode       (out_opcode),
    .out_masked       (out_masked),
    .out_frame_length (out_frame_length),
    .out_data_byte    (out_data_byte),
    .out_last         (out_last),
    .n_errors         (n_errors),
    .n_pending        (n_pending),
    .n_headers        (n_headers),
    .n_payload        (n_payload)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", n_pending);
    $display("*** FAILED ***");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b);
    int r;
    int n;
    r = $urandom_range(0, 99);
    n = 0;
    if (!quiet) begin
      if (r < 25) n = $urandom_range(1, 3);
      else if (r < 31) n = $urandom_range(4, 12);
      else if (r < 33) n = $urandom_range(20, 60);
    end
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (in_stall);
    sent_bytes++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (n_pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_frame(input logic fin, input logic [2:0] rsv, input logic [3:0] op,
                            input logic msk, input len_form_t form,
                            input logic [63:0] len, input int n_bytes);
    logic [31:0] key;
    key = $urandom;
    send_byte({fin, rsv, op});
    case (form)
      FORM_16: begin
        send_byte({msk, Len16Code});
        send_byte(len[15:8]);
        send_byte(len[7:0]);
      end
      FORM_64: begin
        send_byte({msk, Len64Code});
        for (int i = 7; i >= 0; i--) send_byte(len[8*i +: 8]);
      end
      default: send_byte({msk, len[6:0]});
    endcase
    if (msk)
      for (int i = 3; i >= 0; i--) send_byte(key[8*i +: 8]);
    for (int i = 0; i < n_bytes; i++) send_byte(8'($urandom));
    sent_frames++;
  endtask

  task automatic send_random_frame();
    int r;
    len_form_t form;
    int len;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      form = FORM_7;
      len = $urandom_range(0, 12);
    end else if (r < 70) begin
      form = FORM_7;
      len = $urandom_range(0, 125);
    end else if (r < 85) begin
      form = FORM_16;
      len = $urandom_range(0, 40);
    end else if (r < 90) begin
      form = FORM_16;
      len = $urandom_range(126, 300);
    end else begin
      form = FORM_64;
      len = $urandom_range(0, 20);
    end
    quiet = ($urandom_range(0, 3) == 0);
    send_frame(1'($urandom_range(0, 1)), 3'($urandom), 4'($urandom),
               1'($urandom_range(0, 1)), form, 64'(len), len);
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_byte   <= 8'h00;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty frame, masked with key wrap, reserved bits and unknown opcode,
    // non-minimal extended lengths
    send_frame(1'b1, 3'b000, 4'h1, 1'b0, FORM_7, 64'd0, 0);
    send_frame(1'b1, 3'b000, 4'h2, 1'b1, FORM_7, 64'd5, 5);
    send_frame(1'b0, 3'b111, 4'hF, 1'b0, FORM_7, 64'd1, 1);
    send_frame(1'b1, 3'b000, 4'h8, 1'b0, FORM_16, 64'd2, 2);
    send_frame(1'b1, 3'b000, 4'h9, 1'b1, FORM_64, 64'd0, 0);
    wait_drained();

    while (sent_bytes < 820) begin
      send_random_frame();
      if (sent_frames == 60) wait_drained();
    end

    // 64-bit length with the top bit set: payload never completes within the run
    quiet = 1'b0;
    send_frame(1'b1, 3'b000, 4'hA, 1'b1, FORM_64, 64'hFFFF_FFFF_FFFF_FFFF, 6);
    wait_drained();
    repeat (8) @(posedge clk);

    $display("Sent %0d bytes in %0d frames under random gaps and stalls;", sent_bytes,
             sent_frames);
    $display("checked %0d header reports and %0d payload bytes.", n_headers, n_payload);
    if (n_errors == 0 && n_pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    int mode;
    out_stall <= 1'b0;
    forever begin
      mode = $urandom_range(0, 9);
      repeat ($urandom_range(4, 40)) begin
        @(posedge clk);
        if (mode < 4) out_stall <= 1'b0;
        else if (mode < 9) out_stall <= ($urandom_range(0, 2) == 0);
        else out_stall <= 1'b1;
      end
    end
  end

endmodule
